>>> hw/rtl/deqsr_pkg.sv
// Shared types and constants for the deque with search and remove.
// Holds request and status codes and the controller/datapath interface structs.
// No dependencies.
package deqsr_pkg;

   localparam int DEPTH_DFLT = 16;
   localparam int FUNC_W     = 3;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_SEARCH     = 3'd4,
      FUNC_REMOVE     = 3'd5,
      FUNC_CLEAR      = 3'd6,
      FUNC_NOP        = 3'd7
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } stat_type;

   // controller -> datapath
   typedef struct packed {
      logic     capture;
      logic     wr_front;
      logic     wr_back;
      logic     rd_front;
      logic     rd_back;
      logic     scan_start;
      logic     scan_step;
      logic     shift_start;
      logic     shift_step;
      logic     front_inc;
      logic     count_dec;
      logic     clear;
      logic     respond;
      stat_type status;
      logic     rsp_data;
      logic     rsp_pos;
      logic     rsp_held;
   } deqsr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      func_type func;
      logic     full;
      logic     empty;
      logic     hit;
      logic     at_first;
      logic     at_last;
      logic     shift_last;
   } deqsr_sts_type;

endpackage

>>> hw/rtl/deque_with_search_and_remove_top.sv
// Top level of the bounded deque with search and remove.
// Depends on deqsr_pkg, deqsr_ctrl and deqsr_dp.
//
// Usage: drive req_func and req_value with start high; the request is taken
// at a rising edge where busy is low. busy stays high until the request's
// single result has been registered. The result appears on rsp_status,
// rsp_data_out, rsp_position and rsp_count_after for exactly one cycle,
// marked by rsp_valid; the receiver cannot stall it.
// Steps from acceptance to rsp_valid:
//   push, clear, unused code, any failure on a full/empty store: decode only
//   pop front/back: decode, then one registered read of the ring store
//   search/remove: the scan compares one entry per cycle from the front
//   until a match or the last entry.
//   remove in the middle then moves each later entry down one slot, one
//   read and one write of the single-port-pair ring store per cycle.
// A new request is taken in the cycle rsp_valid is shown; none is taken
// while busy, so requests do not overlap.
// Reset (synchronous) empties the deque; store contents are not cleared.
module deque_with_search_and_remove_top #(
   parameter int DEPTH = deqsr_pkg::DEPTH_DFLT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [deqsr_pkg::FUNC_W-1:0]         req_func,
   input  logic signed [deqsr_pkg::VALUE_W-1:0] req_value,
   output logic                                 rsp_valid,
   output logic [deqsr_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [deqsr_pkg::VALUE_W-1:0] rsp_data_out,
   output logic [deqsr_pkg::POS_W-1:0]          rsp_position,
   output logic [deqsr_pkg::POS_W-1:0]          rsp_count_after
);
   import deqsr_pkg::*;

   deqsr_cmd_type cmd;
   deqsr_sts_type sts;

   deqsr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   deqsr_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_position    (rsp_position),
      .rsp_count_after (rsp_count_after)
   );

endmodule

>>> hw/rtl/deqsr_ctrl.sv
// Request sequencer for the deque: one-hot state machine issuing datapath commands.
// Depends on deqsr_pkg.
module deqsr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  deqsr_pkg::deqsr_sts_type sts,
   output deqsr_pkg::deqsr_cmd_type cmd
);
   import deqsr_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_DECODE   = 5'b00010,
      ST_POP_WAIT = 5'b00100,
      ST_SCAN     = 5'b01000,
      ST_SHIFT    = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            case (sts.func)
               FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                  cmd.respond = 1'b1;
                  if (sts.full) begin
                     cmd.status = STAT_FULL;
                  end else begin
                     cmd.status   = STAT_OK;
                     cmd.wr_front = (sts.func == FUNC_PUSH_FRONT);
                     cmd.wr_back  = (sts.func == FUNC_PUSH_BACK);
                  end
               end
               FUNC_POP_FRONT, FUNC_POP_BACK: begin
                  if (sts.empty) begin
                     cmd.respond = 1'b1;
                     cmd.status  = STAT_EMPTY;
                  end else begin
                     cmd.rd_front = (sts.func == FUNC_POP_FRONT);
                     cmd.rd_back  = (sts.func == FUNC_POP_BACK);
                     state_in     = ST_POP_WAIT;
                  end
               end
               FUNC_SEARCH, FUNC_REMOVE: begin
                  if (sts.empty) begin
                     cmd.respond = 1'b1;
                     cmd.status  = STAT_EMPTY;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
               FUNC_CLEAR: begin
                  cmd.clear   = 1'b1;
                  cmd.respond = 1'b1;
                  cmd.status  = STAT_OK;
               end
               default: begin
                  cmd.respond = 1'b1;
                  cmd.status  = STAT_OK;
               end
            endcase
         end
         ST_POP_WAIT: begin
            cmd.respond   = 1'b1;
            cmd.status    = STAT_OK;
            cmd.rsp_data  = 1'b1;
            cmd.count_dec = 1'b1;
            cmd.front_inc = (sts.func == FUNC_POP_FRONT);
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            if (sts.hit) begin
               if (sts.func == FUNC_SEARCH) begin
                  cmd.respond = 1'b1;
                  cmd.status  = STAT_OK;
                  cmd.rsp_pos = 1'b1;
                  state_in    = ST_IDLE;
               end else if (sts.at_first || sts.at_last) begin
                  cmd.respond   = 1'b1;
                  cmd.status    = STAT_OK;
                  cmd.rsp_pos   = 1'b1;
                  cmd.rsp_data  = 1'b1;
                  cmd.count_dec = 1'b1;
                  cmd.front_inc = sts.at_first;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.shift_start = 1'b1;
                  state_in        = ST_SHIFT;
               end
            end else if (sts.at_last) begin
               cmd.respond = 1'b1;
               cmd.status  = STAT_NOT_FOUND;
               state_in    = ST_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (sts.shift_last) begin
               cmd.respond   = 1'b1;
               cmd.status    = STAT_OK;
               cmd.rsp_held  = 1'b1;
               cmd.count_dec = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/deqsr_dp.sv
// Deque datapath: ring store, front index, entry count, scan pointers and result registers.
// Depends on deqsr_pkg; driven by deqsr_ctrl commands.
module deqsr_dp #(
   parameter int DEPTH = deqsr_pkg::DEPTH_DFLT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  deqsr_pkg::deqsr_cmd_type             cmd,
   output deqsr_pkg::deqsr_sts_type             sts,
   input  logic [deqsr_pkg::FUNC_W-1:0]         req_func,
   input  logic signed [deqsr_pkg::VALUE_W-1:0] req_value,
   output logic                                 rsp_valid,
   output logic [deqsr_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [deqsr_pkg::VALUE_W-1:0] rsp_data_out,
   output logic [deqsr_pkg::POS_W-1:0]          rsp_position,
   output logic [deqsr_pkg::POS_W-1:0]          rsp_count_after
);
   import deqsr_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
      return (s == AW'(DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
      return (s == '0) ? AW'(DEPTH - 1) : s - 1'b1;
   endfunction

   logic [VALUE_W-1:0] mem [DEPTH];

   func_type           func_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [AW-1:0]      front_ff, front_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      rd_slot_ff, cmp_slot_ff;
   logic [CW-1:0]      cmp_k_ff;
   logic [VALUE_W-1:0] rd_data_ff;
   logic [VALUE_W-1:0] hold_data_ff;
   logic [CW-1:0]      hold_pos_ff;

   logic               rsp_valid_ff;
   stat_type           rsp_status_ff;
   logic [VALUE_W-1:0] rsp_data_ff;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_count_ff;

   logic [AW:0]        back_sum, back_wrap;
   logic [AW-1:0]      back_slot, last_slot;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic               wr_en;
   logic [CW-1:0]      cmp_pos;
   logic [CW:0]        cmp_k_p2;
   logic [CW-1:0]      pos_sel;
   logic [CW+POS_W-1:0] pos_ext, cnt_ext;

   // ring slot arithmetic
   assign back_sum  = {1'b0, front_ff} + (AW+1)'(count_ff);
   assign back_wrap = (back_sum >= (AW+1)'(DEPTH)) ? back_sum - (AW+1)'(DEPTH) : back_sum;
   assign back_slot = back_wrap[AW-1:0];
   assign last_slot = slot_dec(back_slot);
   assign cmp_pos   = cmp_k_ff + 1'b1;
   assign cmp_k_p2  = {1'b0, cmp_k_ff} + (CW+1)'(2);

   // status to controller
   assign sts.func       = func_ff;
   assign sts.full       = (count_ff == CW'(DEPTH));
   assign sts.empty      = (count_ff == '0);
   assign sts.hit        = (rd_data_ff == value_ff);
   assign sts.at_first   = (cmp_k_ff == '0);
   assign sts.at_last    = (cmp_pos == count_ff);
   assign sts.shift_last = (cmp_k_p2 == {1'b0, count_ff});

   // memory ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cmp_slot_ff;
      wr_data = rd_data_ff;
      if (cmd.wr_front) begin
         wr_en   = 1'b1;
         wr_addr = slot_dec(front_ff);
         wr_data = value_ff;
      end else if (cmd.wr_back) begin
         wr_en   = 1'b1;
         wr_addr = back_slot;
         wr_data = value_ff;
      end else if (cmd.shift_step) begin
         wr_en   = 1'b1;
      end
   end

   always_comb begin
      rd_addr = rd_slot_ff;
      if (cmd.rd_front || cmd.scan_start) begin
         rd_addr = front_ff;
      end else if (cmd.rd_back) begin
         rd_addr = last_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // queue pointers
   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      if (cmd.clear) begin
         front_in = '0;
         count_in = '0;
      end else if (cmd.wr_front) begin
         front_in = slot_dec(front_ff);
         count_in = count_ff + 1'b1;
      end else if (cmd.wr_back) begin
         count_in = count_ff + 1'b1;
      end else begin
         if (cmd.front_inc) begin
            front_in = slot_inc(front_ff);
         end
         if (cmd.count_dec) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   // request capture, scan and shift pointers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= func_type'(req_func);
         value_ff <= req_value;
      end
      if (cmd.scan_start) begin
         rd_slot_ff  <= slot_inc(front_ff);
         cmp_slot_ff <= front_ff;
         cmp_k_ff    <= '0;
      end else if (cmd.scan_step || cmd.shift_step) begin
         rd_slot_ff  <= slot_inc(rd_slot_ff);
         cmp_slot_ff <= slot_inc(cmp_slot_ff);
         cmp_k_ff    <= cmp_pos;
      end else if (cmd.shift_start) begin
         rd_slot_ff  <= slot_inc(rd_slot_ff);
      end
      if (cmd.shift_start) begin
         hold_data_ff <= rd_data_ff;
         hold_pos_ff  <= cmp_pos;
      end
   end

   // result registers
   assign pos_sel = cmd.rsp_held ? hold_pos_ff : cmp_pos;
   assign pos_ext = {{POS_W{1'b0}}, pos_sel};
   assign cnt_ext = {{POS_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status_ff <= cmd.status;
         rsp_count_ff  <= cnt_ext[POS_W-1:0];
         if (cmd.rsp_held) begin
            rsp_data_ff <= hold_data_ff;
         end else if (cmd.rsp_data) begin
            rsp_data_ff <= rd_data_ff;
         end else begin
            rsp_data_ff <= '0;
         end
         if (cmd.rsp_held || cmd.rsp_pos) begin
            rsp_pos_ff <= pos_ext[POS_W-1:0];
         end else begin
            rsp_pos_ff <= '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_count_after = rsp_count_ff;

endmodule
